[sv/combined_lcg_shuffle_rng_macros.svh]
// Assertion macros for the combined generator.
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH

`ifndef SYNTH
`define CLSR_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define CLSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CLSR_ASSERT(lbl, clk, rstn, expr)
`define CLSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/clsr_pkg.sv]
`default_nettype none

package clsr_pkg;

    localparam logic [30:0] MOD_ONE      = 31'd2147483563;
    localparam logic [30:0] MOD_TWO      = 31'd2147483399;
    localparam logic [30:0] MOD_ONE_LESS = 31'd2147483562;
    localparam logic [15:0] MUL_ONE      = 16'd40014;
    localparam logic [15:0] MUL_TWO      = 16'd40692;
    localparam logic [7:0]  FOLD_ONE     = 8'd85;
    localparam logic [7:0]  FOLD_TWO     = 8'd249;
    localparam logic [30:0] GEN_TWO_INIT = 31'd123456789;
    localparam logic [23:0] FRAC_MAX     = 24'd16777213;
    localparam int          WARMUP_EXTRA = 8;

    // (a * x) mod m for m = 2^31 - c: fold the high part back in, then one subtract
    function automatic logic [30:0] mcg_reduce(input logic [46:0] prod,
                                               input logic [30:0] m,
                                               input logic [7:0]  c);
        logic [31:0] fold;
        logic [31:0] diff;
        fold = {1'b0, prod[30:0]} + 32'(prod[46:31]) * 32'(c);
        diff = fold - {1'b0, m};
        mcg_reduce = (fold >= {1'b0, m}) ? diff[30:0] : fold[30:0];
    endfunction

    // floor(s * 2^24 / MOD_ONE), clamped to FRAC_MAX
    function automatic logic [23:0] to_fraction(input logic [30:0] s);
        logic [23:0] q0;
        logic [31:0] rem;
        logic [24:0] q;
        q0  = s[30:7];
        rem = {1'b0, s[6:0], 24'd0} + 32'(q0) * 32'(FOLD_ONE);
        q   = {1'b0, q0} + 25'(rem >= {1'b0, MOD_ONE});
        to_fraction = (q > {1'b0, FRAC_MAX}) ? FRAC_MAX : q[23:0];
    endfunction

endpackage

`default_nettype wire

[sv/combined_lcg_shuffle_rng.sv]
// Combined congruential random generator with a shuffle table.
// Input channel: i_valid / o_stall carry a request of i_cmd and i_seed.
//   i_cmd = 0 draws the next number; i_cmd = 1 reseeds from i_seed, then draws.
// Output channel: o_valid / i_stall carry o_sample (1..2147483562) and
//   o_fraction (sample over the first modulus as a 0.24 fraction).
// One request yields exactly one result. A request is taken only while the
// sequencer is idle; o_stall is high for the whole of its work.
// A draw runs, after accept, through the two generator steps on the shared
//   multiplier and fold unit, the slot index (reciprocal multiply, multiply
//   back, correct) on the same multiplier, then table access, mix and
//   output load.
// A reseed first runs warm-up steps on the same multiplier, then draws.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, a finished result holds in the sequencer
// until the output register is free.
// Reset (synchronous, active low) clears both generators to their start
// values, the previous output, and the table valid bits, so the table reads
// as all zeros until written.
`default_nettype none

module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [30:0] i_seed,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [30:0]      o_sample,
    output logic [23:0]      o_fraction
);
    import clsr_pkg::*;
    `include "combined_lcg_shuffle_rng_macros.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW = $clog2(TABLE_DEPTH) + 1;
    localparam int CW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
    localparam longint SLOT_DIV = 1 + 2147483562 / TABLE_DEPTH;
    localparam longint RECIP = (longint'(1) << 31) / SLOT_DIV;
    localparam logic [30:0] SLOT_DIV_X = 31'(SLOT_DIV);
    localparam logic [15:0] RECIP_A    = 16'(RECIP);
    localparam logic [CW-1:0] WARM_LAST = CW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
    localparam logic [CW-1:0] DEPTH_CW  = CW'(TABLE_DEPTH);
    localparam logic [QW-1:0] DEPTH_QW  = QW'(TABLE_DEPTH);
    localparam logic [AW-1:0] SLOT_MAX  = AW'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_W_MUL, S_W_RED, S_D_MUL1, S_D_RED1, S_D_MUL2, S_D_RED2,
        S_Q_MUL, S_Q_BACK, S_Q_FIX, S_READ, S_MIX, S_DONE
    } t_state;

    t_state            r_state;
    logic [30:0]       r_gen_one;
    logic [30:0]       r_gen_two;
    logic [30:0]       r_last;
    logic [46:0]       r_prod;
    logic [CW-1:0]     r_cnt;
    logic [QW-1:0]     r_quo;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic              r_rd_valid;
    logic [30:0]       r_rd;
    logic [30:0]       r_table [TABLE_DEPTH];

    logic [30:0]       mul_x;
    logic [15:0]       mul_a;
    logic [30:0]       red;
    logic [30:0]       seed_c;
    logic [15:0]       q_est;
    logic [30:0]       rem_fix;
    logic              fix_ge;
    logic [AW-1:0]     slot;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [30:0]       mem_wdata;
    logic [30:0]       old_val;
    logic signed [32:0] mix0;
    logic signed [32:0] mix1;
    logic [30:0]       mix;
    logic              out_free;
    logic              load_out;

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign load_out = (r_state == S_DONE) && out_free;

    assign q_est   = r_prod[46:31];
    assign rem_fix = r_last - r_prod[30:0];
    assign fix_ge  = (rem_fix >= SLOT_DIV_X);

    always_comb begin
        case (r_state)
            S_D_MUL2: begin
                mul_x = r_gen_two;
                mul_a = MUL_TWO;
            end
            S_Q_MUL: begin
                mul_x = r_last;
                mul_a = RECIP_A;
            end
            S_Q_BACK: begin
                mul_x = SLOT_DIV_X;
                mul_a = q_est;
            end
            default: begin
                mul_x = r_gen_one;
                mul_a = MUL_ONE;
            end
        endcase
        if (r_state == S_D_RED2) begin
            red = mcg_reduce(r_prod, MOD_TWO, FOLD_TWO);
        end else begin
            red = mcg_reduce(r_prod, MOD_ONE, FOLD_ONE);
        end
    end

    always_comb begin
        if (i_seed == 31'd0) begin
            seed_c = 31'd1;
        end else if (i_seed > MOD_ONE_LESS) begin
            seed_c = MOD_ONE_LESS;
        end else begin
            seed_c = i_seed;
        end
    end

    assign slot = (r_quo >= DEPTH_QW) ? SLOT_MAX : r_quo[AW-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = slot;
        mem_wdata = r_gen_one;
        if (r_state == S_W_RED) begin
            mem_we    = (r_cnt < DEPTH_CW);
            mem_addr  = r_cnt[AW-1:0];
            mem_wdata = red;
        end else if (r_state == S_READ) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        old_val = r_rd_valid ? r_rd : 31'd0;
        mix0 = $signed({2'b00, old_val}) - $signed({2'b00, r_gen_two});
        if (mix0 < 33'sd1) begin
            mix1 = mix0 + $signed({2'b00, MOD_ONE_LESS});
        end else begin
            mix1 = mix0;
        end
        if (mix1 < 33'sd1) begin
            mix = 31'd1;
        end else if (mix1 > $signed({2'b00, MOD_ONE_LESS})) begin
            mix = MOD_ONE_LESS;
        end else begin
            mix = mix1[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_addr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd <= r_table[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gen_one  <= 31'd0;
            r_gen_two  <= GEN_TWO_INIT;
            r_last     <= 31'd0;
            r_valid    <= '0;
            o_valid    <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd) begin
                            r_gen_one <= seed_c;
                            r_gen_two <= GEN_TWO_INIT;
                            r_cnt     <= WARM_LAST;
                            r_state   <= S_W_MUL;
                        end else begin
                            r_state <= S_D_MUL1;
                        end
                    end
                end
                S_W_MUL: begin
                    r_prod  <= 47'(mul_x) * 47'(mul_a);
                    r_state <= S_W_RED;
                end
                S_W_RED: begin
                    r_gen_one <= red;
                    if (mem_we) begin
                        r_valid[mem_addr] <= 1'b1;
                    end
                    if (r_cnt == '0) begin
                        r_last  <= red;
                        r_state <= S_D_MUL1;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_W_MUL;
                    end
                end
                S_D_MUL1: begin
                    r_prod  <= 47'(mul_x) * 47'(mul_a);
                    r_state <= S_D_RED1;
                end
                S_D_RED1: begin
                    r_gen_one <= red;
                    r_state   <= S_D_MUL2;
                end
                S_D_MUL2: begin
                    r_prod  <= 47'(mul_x) * 47'(mul_a);
                    r_state <= S_D_RED2;
                end
                S_D_RED2: begin
                    r_gen_two <= red;
                    r_state   <= S_Q_MUL;
                end
                S_Q_MUL: begin
                    r_prod  <= 47'(mul_x) * 47'(mul_a);
                    r_state <= S_Q_BACK;
                end
                S_Q_BACK: begin
                    r_quo   <= q_est[QW-1:0];
                    r_prod  <= 47'(mul_x) * 47'(mul_a);
                    r_state <= S_Q_FIX;
                end
                S_Q_FIX: begin
                    r_quo   <= r_quo + QW'(fix_ge);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_rd_valid     <= r_valid[mem_addr];
                    r_valid[mem_addr] <= 1'b1;
                    r_state        <= S_MIX;
                end
                S_MIX: begin
                    r_last  <= mix;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_sample   <= r_last;
                        o_fraction <= to_fraction(r_last);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CLSR_ASSERT(a_sample_range, i_clk, i_rst_n, !o_valid || ((o_sample != 31'd0) && (o_sample <= MOD_ONE_LESS)))
    `CLSR_ASSERT(a_fraction_max, i_clk, i_rst_n, !o_valid || (o_fraction <= FRAC_MAX))
    `CLSR_ASSERT(a_gen_one_range, i_clk, i_rst_n, r_gen_one < MOD_ONE)
    `CLSR_ASSERT(a_gen_two_range, i_clk, i_rst_n, (r_gen_two < MOD_TWO) && (r_gen_two != 31'd0))
    `CLSR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;

    localparam longint unsigned MOD_ONE      = 64'd2147483563;
    localparam longint unsigned MOD_TWO      = 64'd2147483399;
    localparam longint unsigned MOD_ONE_LESS = 64'd2147483562;
    localparam longint unsigned MUL_ONE      = 64'd40014;
    localparam longint unsigned MUL_TWO      = 64'd40692;
    localparam bit [30:0]       GEN_TWO_SEED = 31'd123456789;
    localparam int              SLOT_COUNT   = 32;
    localparam int              WARMUP_EXTRA = 8;
    localparam longint unsigned SLOT_DIV     = 64'd1 + MOD_ONE_LESS / SLOT_COUNT;
    localparam longint unsigned FRAC_TOP     = 64'd16777213;
    localparam int              SETTLE       = 120;
    localparam int              CYCLE_LIMIT  = 1000000;
    localparam int              RANDOM_ITEMS = 700;

    typedef enum bit {CMD_DRAW = 1'b0, CMD_RESEED = 1'b1} t_cmd;

    typedef struct {
        bit [30:0] sample;
        bit [23:0] fraction;
    } t_draw;

    class t_draw_tracker;
        bit [30:0] gen_one;
        bit [30:0] gen_two;
        bit [30:0] prev_sample;
        bit [30:0] slots [SLOT_COUNT];
        t_draw     expected_draws [$];
        int        errors;

        function new();
            gen_one     = '0;
            gen_two     = GEN_TWO_SEED;
            prev_sample = '0;
            foreach (slots[i]) slots[i] = '0;
            errors      = 0;
        endfunction

        function bit [30:0] advance(bit [30:0] x, longint unsigned mul,
                                    longint unsigned modulus);
            longint unsigned prod;
            prod = mul * longint'(x);
            return 31'(prod % modulus);
        endfunction

        function void reseed_state(bit [30:0] seed);
            bit [30:0] g;
            g = (seed == 0) ? 31'd1 : seed;
            if (g > MOD_ONE_LESS) g = 31'(MOD_ONE_LESS);
            gen_two = GEN_TWO_SEED;
            for (int j = SLOT_COUNT + WARMUP_EXTRA - 1; j >= 0; j--) begin
                g = advance(g, MUL_ONE, MOD_ONE);
                if (j < SLOT_COUNT) slots[j] = g;
            end
            gen_one     = g;
            prev_sample = slots[0];
        endfunction

        function bit [30:0] next_sample();
            longint unsigned slot;
            longint          mix;
            gen_one = advance(31'(longint'(gen_one) % MOD_ONE), MUL_ONE, MOD_ONE);
            gen_two = advance(31'(longint'(gen_two) % MOD_TWO), MUL_TWO, MOD_TWO);
            slot = longint'(prev_sample) / SLOT_DIV;
            if (slot >= SLOT_COUNT) slot = SLOT_COUNT - 1;
            mix = longint'(slots[slot]) - longint'(gen_two);
            slots[slot] = gen_one;
            if (mix < 1) mix += longint'(MOD_ONE_LESS);
            if (mix < 1) mix = 1;
            if (mix > longint'(MOD_ONE_LESS)) mix = longint'(MOD_ONE_LESS);
            prev_sample = 31'(mix);
            return prev_sample;
        endfunction

        function void note_request(t_cmd cmd, bit [30:0] seed);
            t_draw           d;
            longint unsigned q;
            if (cmd == CMD_RESEED) reseed_state(seed);
            d.sample = next_sample();
            q = (longint'(d.sample) << 24) / MOD_ONE;
            if (q > FRAC_TOP) q = FRAC_TOP;
            d.fraction = 24'(q);
            expected_draws.insert(expected_draws.size(), d);
        endfunction

        function void check_draw(bit [30:0] sample, bit [23:0] fraction);
            t_draw d;
            if (expected_draws.size() == 0) begin
                $error("unexpected result: sample %0d, fraction %0d", sample, fraction);
                errors++;
                return;
            end
            d = expected_draws.pop_front();
            if (sample !== d.sample) begin
                $error("sample mismatch: expected %0d, actual %0d", d.sample, sample);
                errors++;
            end
            if (fraction !== d.fraction) begin
                $error("fraction mismatch: expected %0d, actual %0d", d.fraction, fraction);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_cmd   = 1'b0;
    logic [30:0] i_seed  = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [30:0] o_sample;
    logic [23:0] o_fraction;

    t_draw_tracker draws;
    int          cycles     = 0;
    int          stall_left = 0;
    bit          send_calm  = 1'b0;
    bit          recv_calm  = 1'b0;

    combined_lcg_shuffle_rng DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_seed     (i_seed),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sample   (o_sample),
        .o_fraction (o_fraction)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [30:0] pick_seed();
        case ($urandom_range(0, 11))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return 31'(MOD_ONE_LESS);
            3:       return 31'($urandom_range(32'd2147483563, 32'h7FFF_FFFF));
            default: return 31'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** combined_lcg_shuffle_rng: FAILED **");
            $finish;
        end
        if (cycles % 256 == 0) begin
            send_calm <= ($urandom_range(0, 3) == 0);
            recv_calm <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) draws.check_draw(o_sample, o_fraction);
            if (stall_left != 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall    <= 1'b0;
                stall_left <= idle_len(recv_calm);
            end
        end
    end

    task automatic send_request(t_cmd cmd, bit [30:0] seed);
        int gap;
        gap = idle_len(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_seed  <= seed;
        do @(posedge i_clk); while (o_stall);
        draws.note_request(cmd, seed);
    endtask

    initial begin
        draws = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // draw on the reset state before any reseed
        send_request(CMD_DRAW, 31'd0);
        send_request(CMD_DRAW, 31'h7FFF_FFFF);
        send_request(CMD_DRAW, 31'h5555_5555);
        send_request(CMD_RESEED, 31'd0);
        send_request(CMD_DRAW, 31'h2AAA_AAAA);
        send_request(CMD_RESEED, 31'd1);
        send_request(CMD_DRAW, 31'd0);
        send_request(CMD_RESEED, 31'(MOD_ONE_LESS));
        send_request(CMD_DRAW, 31'd0);
        send_request(CMD_RESEED, 31'd2147483563);
        send_request(CMD_DRAW, 31'd0);
        send_request(CMD_RESEED, 31'h7FFF_FFFF);
        send_request(CMD_DRAW, 31'd0);
        send_request(CMD_RESEED, 31'h5555_5555);
        send_request(CMD_RESEED, 31'h2AAA_AAAA);
        send_request(CMD_DRAW, 31'd0);
        send_request(CMD_RESEED, 31'd123456789);
        for (int k = 0; k < 5; k++) send_request(CMD_DRAW, 31'($urandom));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 8) send_request(CMD_RESEED, pick_seed());
            else send_request(CMD_DRAW, 31'($urandom));
        end
        i_valid <= 1'b0;

        while (draws.expected_draws.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (draws.errors == 0 && draws.expected_draws.size() == 0) begin
            $display("** combined_lcg_shuffle_rng: PASSED **");
        end else begin
            $display("** combined_lcg_shuffle_rng: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
